[sv/mcsc_pkg.sv]
// Shared types and constants for the multi-criteria score compare unit.
package mcsc_pkg;

    localparam int DEFAULT_MAX_CRITERIA = 16;
    localparam int DEFAULT_VALUE_WIDTH  = 24;

    localparam int MODE_WIDTH    = 2;
    localparam int VOTE_WIDTH    = 6;
    localparam int VERDICT_WIDTH = 2;

    localparam logic signed [VOTE_WIDTH-1:0] VOTE_MAX = {1'b0, {(VOTE_WIDTH-1){1'b1}}};
    localparam logic signed [VOTE_WIDTH-1:0] VOTE_MIN = {1'b1, {(VOTE_WIDTH-1){1'b0}}};

    typedef logic signed [VERDICT_WIDTH-1:0] verdict_t;

    localparam verdict_t VERDICT_TIE = 2'sb00;
    localparam verdict_t VERDICT_A   = 2'sb01;
    localparam verdict_t VERDICT_B   = 2'sb11;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_WEIGHTED_SUM = 2'd0,
        MODE_MAJORITY     = 2'd1,
        MODE_LEXICOGRAPHIC = 2'd2,
        MODE_GROUP        = 2'd3
    } compare_mode_t;

endpackage

[sv/multi_criteria_score_compare_unit.sv]
// Top level of the multi-criteria score compare unit.
//
// Each input transaction carries one criterion (weight and score for
// candidates A and B); the transaction flagged last_criterion closes the
// comparison and yields one verdict transaction (+1 A better, -1 B better,
// 0 tie or fault) chosen by the compare mode register. The block takes one
// criterion per clock cycle while in_stall is low; a verdict passes from
// the input register through the product, difference and accumulate/result
// registers behind it. Every stage holds its own valid bit, so bubbles
// collapse and input transactions keep flowing while a verdict waits in
// the output register, until the next last criterion reaches stage 3.
module multi_criteria_score_compare_unit #(
    parameter int MAX_CRITERIA = mcsc_pkg::DEFAULT_MAX_CRITERIA,
    parameter int VALUE_WIDTH  = mcsc_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write_en,
    input  logic [mcsc_pkg::MODE_WIDTH-1:0]       cfg_write_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [VALUE_WIDTH-1:0]         weight_a,
    input  logic signed [VALUE_WIDTH-1:0]         score_a,
    input  logic signed [VALUE_WIDTH-1:0]         weight_b,
    input  logic signed [VALUE_WIDTH-1:0]         score_b,
    input  logic                                  element_ok,
    input  logic                                  last_criterion,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mcsc_pkg::VERDICT_WIDTH-1:0] verdict
);

    localparam int PROD_WIDTH = 2 * VALUE_WIDTH;
    localparam int DIFF_WIDTH = PROD_WIDTH + 1;
    localparam int SUM_WIDTH  = PROD_WIDTH + $clog2(MAX_CRITERIA) + 1;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // Configuration.
    mcsc_pkg::compare_mode_t mode_reg;

    // Stage 1: input register.
    logic                          s1_valid_reg;
    logic signed [VALUE_WIDTH-1:0] s1_wa_reg, s1_sa_reg, s1_wb_reg, s1_sb_reg;
    logic                          s1_ok_reg, s1_last_reg;

    // Stage 2: products.
    logic                          s2_valid_reg;
    logic signed [PROD_WIDTH-1:0]  s2_pa_reg, s2_pb_reg;
    logic                          s2_ok_reg, s2_last_reg;

    // Stage 3: difference and comparison flags.
    logic                          s3_valid_reg;
    logic signed [DIFF_WIDTH-1:0]  s3_diff_reg;
    logic                          s3_gt_reg, s3_lt_reg;
    logic                          s3_ok_reg, s3_last_reg;

    // Accumulated comparison state.
    logic signed [SUM_WIDTH-1:0]                 sum_reg, sum_next;
    logic signed [mcsc_pkg::VOTE_WIDTH-1:0]      vote_reg, vote_next;
    mcsc_pkg::verdict_t                          lex_verdict_reg, lex_verdict_next;
    logic                                        lex_decided_reg, lex_decided_next;
    logic                                        fault_reg, fault_next;

    // Output register.
    logic                                        out_valid_reg;
    mcsc_pkg::verdict_t                          out_verdict_reg, verdict_next;

    logic                          out_free, adv3, rdy3, rdy2, rdy1;
    logic                          s1_accept;
    logic signed [PROD_WIDTH-1:0]  pa_next, pb_next;
    logic signed [DIFF_WIDTH-1:0]  diff_next;
    logic signed [SUM_WIDTH:0]     sum_wide;

    assign out_free  = !out_valid_reg || !out_stall;
    assign adv3      = s3_valid_reg && (!s3_last_reg || out_free);
    assign rdy3      = !s3_valid_reg || adv3;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign in_stall  = !rdy1;
    assign s1_accept = in_valid && rdy1;

    assign out_valid = out_valid_reg;
    assign verdict   = out_verdict_reg;

    assign pa_next   = s1_wa_reg * s1_sa_reg;
    assign pb_next   = s1_wb_reg * s1_sb_reg;
    assign diff_next = {s2_pa_reg[PROD_WIDTH-1], s2_pa_reg}
                     - {s2_pb_reg[PROD_WIDTH-1], s2_pb_reg};

    always_comb
    begin
        fault_next = fault_reg || !s3_ok_reg;

        sum_wide = {sum_reg[SUM_WIDTH-1], sum_reg}
                 + {{(SUM_WIDTH+1-DIFF_WIDTH){s3_diff_reg[DIFF_WIDTH-1]}}, s3_diff_reg};
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
        begin
            sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[SUM_WIDTH-1:0];
        end

        vote_next = vote_reg;
        if (s3_gt_reg && (vote_reg != mcsc_pkg::VOTE_MAX))
        begin
            vote_next = vote_reg + 1'b1;
        end
        else if (s3_lt_reg && (vote_reg != mcsc_pkg::VOTE_MIN))
        begin
            vote_next = vote_reg - 1'b1;
        end

        lex_verdict_next = lex_verdict_reg;
        lex_decided_next = lex_decided_reg;
        if (!lex_decided_reg && (s3_gt_reg || s3_lt_reg))
        begin
            lex_verdict_next = s3_gt_reg ? mcsc_pkg::VERDICT_A : mcsc_pkg::VERDICT_B;
            lex_decided_next = 1'b1;
        end

        verdict_next = mcsc_pkg::VERDICT_TIE;
        if (!fault_next)
        begin
            case (mode_reg)
                mcsc_pkg::MODE_WEIGHTED_SUM:
                begin
                    if (sum_next[SUM_WIDTH-1])
                        verdict_next = mcsc_pkg::VERDICT_B;
                    else if (|sum_next)
                        verdict_next = mcsc_pkg::VERDICT_A;
                end
                mcsc_pkg::MODE_MAJORITY:
                begin
                    if (vote_next[mcsc_pkg::VOTE_WIDTH-1])
                        verdict_next = mcsc_pkg::VERDICT_B;
                    else if (|vote_next)
                        verdict_next = mcsc_pkg::VERDICT_A;
                end
                mcsc_pkg::MODE_LEXICOGRAPHIC:
                begin
                    verdict_next = lex_verdict_next;
                end
                default:
                begin
                    verdict_next = mcsc_pkg::VERDICT_TIE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= mcsc_pkg::MODE_WEIGHTED_SUM;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            sum_reg         <= '0;
            vote_reg        <= '0;
            lex_verdict_reg <= mcsc_pkg::VERDICT_TIE;
            lex_decided_reg <= 1'b0;
            fault_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= mcsc_pkg::compare_mode_t'(cfg_write_data);
            end

            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end

            if (adv3)
            begin
                if (s3_last_reg)
                begin
                    sum_reg         <= '0;
                    vote_reg        <= '0;
                    lex_verdict_reg <= mcsc_pkg::VERDICT_TIE;
                    lex_decided_reg <= 1'b0;
                    fault_reg       <= 1'b0;
                end
                else
                begin
                    sum_reg         <= sum_next;
                    vote_reg        <= vote_next;
                    lex_verdict_reg <= lex_verdict_next;
                    lex_decided_reg <= lex_decided_next;
                    fault_reg       <= fault_next;
                end
            end

            if (adv3 && s3_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_accept)
        begin
            s1_wa_reg   <= weight_a;
            s1_sa_reg   <= score_a;
            s1_wb_reg   <= weight_b;
            s1_sb_reg   <= score_b;
            s1_ok_reg   <= element_ok;
            s1_last_reg <= last_criterion;
        end

        if (rdy2 && s1_valid_reg)
        begin
            s2_pa_reg   <= pa_next;
            s2_pb_reg   <= pb_next;
            s2_ok_reg   <= s1_ok_reg;
            s2_last_reg <= s1_last_reg;
        end

        if (rdy3 && s2_valid_reg)
        begin
            s3_diff_reg <= diff_next;
            s3_gt_reg   <= (s2_pa_reg > s2_pb_reg);
            s3_lt_reg   <= (s2_pa_reg < s2_pb_reg);
            s3_ok_reg   <= s2_ok_reg;
            s3_last_reg <= s2_last_reg;
        end

        if (adv3 && s3_last_reg)
        begin
            out_verdict_reg <= verdict_next;
        end
    end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the multi-criteria score compare unit.
`timescale 1ns / 100ps

module testbench;

    localparam int VALUE_WIDTH = mcsc_pkg::DEFAULT_VALUE_WIDTH;
    localparam int PIPE_SLACK  = 8;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [mcsc_pkg::VOTE_WIDTH-1:0] vote_t;

    localparam value_t VAL_MAX     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VAL_MIN     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam value_t VAL_ZERO    = '0;
    localparam value_t VAL_ONE     = value_t'(1);
    localparam value_t VAL_NEG_ONE = value_t'(-1);

    localparam vote_t VOTE_ONE = {{(mcsc_pkg::VOTE_WIDTH-1){1'b0}}, 1'b1};

    localparam longint SUM_MAX = (64'sd1 <<< 52) - 64'sd1;
    localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [mcsc_pkg::MODE_WIDTH-1:0] cfg_write_data = mcsc_pkg::MODE_WEIGHTED_SUM;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    value_t                     weight_a = '0;
    value_t                     score_a = '0;
    value_t                     weight_b = '0;
    value_t                     score_b = '0;
    logic                       element_ok = 1'b0;
    logic                       last_criterion = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [mcsc_pkg::VERDICT_WIDTH-1:0] verdict;

    mcsc_pkg::compare_mode_t    mode_setting = mcsc_pkg::MODE_WEIGHTED_SUM;
    longint                     sum_margin = 0;
    vote_t                      vote_margin = '0;
    mcsc_pkg::verdict_t         first_difference = mcsc_pkg::VERDICT_TIE;
    bit                         difference_seen = 1'b0;
    bit                         fault_pending = 1'b0;

    mcsc_pkg::verdict_t         expected_verdicts[$];
    int                         criteria_sent = 0;
    int                         errors = 0;
    bit                         no_idle = 1'b0;

    multi_criteria_score_compare_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .weight_a       (weight_a),
        .score_a        (score_a),
        .weight_b       (weight_b),
        .score_b        (score_b),
        .element_ok     (element_ok),
        .last_criterion (last_criterion),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic mcsc_pkg::verdict_t sign_of(input longint x);
        if (x > 0)
            return mcsc_pkg::VERDICT_A;
        if (x < 0)
            return mcsc_pkg::VERDICT_B;
        return mcsc_pkg::VERDICT_TIE;
    endfunction

    function automatic bit predict_verdict(input value_t wa, input value_t sa,
                                           input value_t wb, input value_t sb,
                                           input bit ok, input bit last,
                                           output mcsc_pkg::verdict_t outcome);
        longint pa;
        longint pb;
        longint total;
        pa = longint'(wa) * longint'(sa);
        pb = longint'(wb) * longint'(sb);
        outcome = mcsc_pkg::VERDICT_TIE;
        if (!ok)
            fault_pending = 1'b1;
        total = sum_margin + (pa - pb);
        if (total > SUM_MAX)
            total = SUM_MAX;
        else if (total < SUM_MIN)
            total = SUM_MIN;
        sum_margin = total;
        if (pa > pb && vote_margin != mcsc_pkg::VOTE_MAX)
            vote_margin = vote_margin + VOTE_ONE;
        else if (pa < pb && vote_margin != mcsc_pkg::VOTE_MIN)
            vote_margin = vote_margin - VOTE_ONE;
        if (!difference_seen && pa != pb)
        begin
            first_difference = sign_of(pa - pb);
            difference_seen = 1'b1;
        end
        if (!last)
            return 1'b0;
        if (!fault_pending)
        begin
            case (mode_setting)
                mcsc_pkg::MODE_WEIGHTED_SUM:  outcome = sign_of(sum_margin);
                mcsc_pkg::MODE_MAJORITY:      outcome = sign_of(longint'(vote_margin));
                mcsc_pkg::MODE_LEXICOGRAPHIC: outcome = first_difference;
                default:                      outcome = mcsc_pkg::VERDICT_TIE;
            endcase
        end
        sum_margin = 0;
        vote_margin = '0;
        first_difference = mcsc_pkg::VERDICT_TIE;
        difference_seen = 1'b0;
        fault_pending = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_criterion(input value_t wa, input value_t sa, input value_t wb,
                                  input value_t sb, input bit ok, input bit last);
        int gap;
        mcsc_pkg::verdict_t outcome;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        weight_a <= wa;
        score_a <= sa;
        weight_b <= wb;
        score_b <= sb;
        element_ok <= ok;
        last_criterion <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        criteria_sent++;
        if (predict_verdict(wa, sa, wb, sb, ok, last, outcome))
            expected_verdicts.push_back(outcome);
    endtask

    task automatic wait_for_verdicts();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_compare_mode(input mcsc_pkg::compare_mode_t mode);
        wait_for_verdicts();
        repeat (PIPE_SLACK) @(posedge clk);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= mode;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        mode_setting = mode;
    endtask

    function automatic value_t random_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return value_t'(int'($urandom_range(0, 2)) - 1);
            3:       return value_t'(int'($urandom_range(0, 8192)) - 4096);
            default: return value_t'($urandom());
        endcase
    endfunction

    task automatic send_random_criterion(input bit last);
        value_t wa;
        value_t sa;
        value_t wb;
        value_t sb;
        int kind;
        wa = random_value();
        sa = random_value();
        wb = random_value();
        sb = random_value();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            wb = wa;
            sb = sa;
        end
        else if (kind == 1)
        begin
            wb = sa;
            sb = wa;
        end
        send_criterion(wa, sa, wb, sb, $urandom_range(0, 32) != 0, last);
    endtask

    task automatic check_reset_mode();
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
        send_criterion(VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, 1'b1, 1'b1);
    endtask

    task automatic check_value_extremes();
        mcsc_pkg::compare_mode_t modes[3] = '{mcsc_pkg::MODE_WEIGHTED_SUM,
                                              mcsc_pkg::MODE_MAJORITY,
                                              mcsc_pkg::MODE_LEXICOGRAPHIC};
        foreach (modes[i])
        begin
            write_compare_mode(modes[i]);
            send_criterion(VAL_ZERO, VAL_ZERO, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
            send_criterion(VAL_MIN, VAL_MAX, VAL_NEG_ONE, VAL_NEG_ONE, 1'b1, 1'b0);
            send_criterion(VAL_MAX, VAL_MAX, VAL_MIN, VAL_ONE, 1'b1, 1'b1);
        end
    endtask

    task automatic check_fault_handling();
        write_compare_mode(mcsc_pkg::MODE_WEIGHTED_SUM);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b0, 1'b0);
        send_criterion(VAL_MAX, VAL_MAX, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
        send_criterion(VAL_MAX, VAL_MAX, VAL_ZERO, VAL_ZERO, 1'b0, 1'b1);
        write_compare_mode(mcsc_pkg::MODE_MAJORITY);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
        send_criterion(VAL_ZERO, VAL_ZERO, VAL_ZERO, VAL_ZERO, 1'b0, 1'b0);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
    endtask

    task automatic check_group_mode();
        write_compare_mode(mcsc_pkg::MODE_GROUP);
        send_criterion(VAL_MAX, VAL_MAX, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
    endtask

    task automatic check_lexicographic_order();
        write_compare_mode(mcsc_pkg::MODE_LEXICOGRAPHIC);
        send_criterion(value_t'(2), value_t'(3), value_t'(3), value_t'(2), 1'b1, 1'b0);
        send_criterion(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 1'b1, 1'b1);
        send_criterion(value_t'(5), value_t'(5), value_t'(5), value_t'(5), 1'b1, 1'b0);
        send_criterion(VAL_ZERO, VAL_ZERO, VAL_ONE, VAL_ONE, 1'b1, 1'b0);
        send_criterion(VAL_MAX, VAL_MAX, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
    endtask

    task automatic check_mode_change_midway();
        write_compare_mode(mcsc_pkg::MODE_MAJORITY);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
        write_compare_mode(mcsc_pkg::MODE_WEIGHTED_SUM);
        send_criterion(VAL_ZERO, VAL_ZERO, VAL_MAX, VAL_MAX, 1'b1, 1'b1);
    endtask

    task automatic check_sum_saturation();
        write_compare_mode(mcsc_pkg::MODE_WEIGHTED_SUM);
        repeat (40) send_criterion(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, 1'b1, 1'b0);
        repeat (32) send_criterion(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, 1'b1, 1'b0);
        send_criterion(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, 1'b1, 1'b1);
        repeat (40) send_criterion(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, 1'b1, 1'b0);
        repeat (32) send_criterion(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, 1'b1, 1'b0);
        send_criterion(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, 1'b1, 1'b1);
    endtask

    task automatic check_vote_saturation();
        write_compare_mode(mcsc_pkg::MODE_MAJORITY);
        repeat (40) send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
        repeat (34) send_criterion(VAL_ZERO, VAL_ZERO, VAL_ONE, VAL_ONE, 1'b1, 1'b0);
        send_criterion(VAL_ZERO, VAL_ZERO, VAL_ONE, VAL_ONE, 1'b1, 1'b1);
        repeat (40) send_criterion(VAL_ZERO, VAL_ZERO, VAL_ONE, VAL_ONE, 1'b1, 1'b0);
        repeat (34) send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b0);
        send_criterion(VAL_ONE, VAL_ONE, VAL_ZERO, VAL_ZERO, 1'b1, 1'b1);
    endtask

    task automatic run_random_comparisons();
        mcsc_pkg::compare_mode_t schedule[4] = '{mcsc_pkg::MODE_GROUP,
                                                 mcsc_pkg::MODE_WEIGHTED_SUM,
                                                 mcsc_pkg::MODE_LEXICOGRAPHIC,
                                                 mcsc_pkg::MODE_MAJORITY};
        mcsc_pkg::compare_mode_t mode;
        int target;
        int length;
        int pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 4)
                mode = schedule[phase];
            else
                mode = mcsc_pkg::compare_mode_t'($urandom_range(mcsc_pkg::MODE_WEIGHTED_SUM,
                                                                mcsc_pkg::MODE_GROUP));
            write_compare_mode(mode);
            no_idle = (phase % 3 == 2);
            target = criteria_sent + 210;
            while (criteria_sent < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 16)
                    length = $urandom_range(1, 6);
                else if (pick < 19)
                    length = $urandom_range(7, 16);
                else
                    length = $urandom_range(17, 48);
                for (int i = 0; i < length; i++)
                    send_random_criterion(i == length - 1);
                if ($urandom_range(0, 49) == 0)
                    wait_for_verdicts();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int wait_cycles;
        forever
        begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
            repeat (wait_cycles)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        mcsc_pkg::verdict_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: verdict transaction with none expected, actual %0d",
                         $time, verdict);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (verdict !== want)
                begin
                    errors++;
                    if (errors < 100)
                        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                 $time, want, verdict);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL multi_criteria_score_compare_unit");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_reset_mode();
        check_value_extremes();
        check_fault_handling();
        check_group_mode();
        check_lexicographic_order();
        check_mode_change_midway();
        check_sum_saturation();
        check_vote_saturation();
        run_random_comparisons();
        wait_for_verdicts();
        repeat (PIPE_SLACK) @(posedge clk);
        if (errors == 0)
            $display("PASS multi_criteria_score_compare_unit");
        else
            $display("FAIL multi_criteria_score_compare_unit");
        $finish;
    end

endmodule

[sim.f]
sv/mcsc_pkg.sv
sv/multi_criteria_score_compare_unit.sv
sim/testbench.sv
